// File: hw/rtl/hex_token_lexer_macros.svh
// Assertion macros for the hex token lexer checker.
`ifndef HEX_TOKEN_LEXER_MACROS_SVH
`define HEX_TOKEN_LEXER_MACROS_SVH

// Checked only while out of reset.
`define HEXLEX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("hexlex assertion failed");

// Checked at every edge, reset included.
`define HEXLEX_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("hexlex assertion failed");

`endif

// File: hw/rtl/hexlex_pkg.sv
package hexlex_pkg;

    // default depth of the result queue; must be at least 3
    localparam int unsigned OQ_DEPTH = 4;

    localparam logic [3:0] MAX_DIGITS = 4'd8;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_HALF      = 3'd1,
        KIND_WORD      = 3'd2,
        KIND_BAD_COUNT = 3'd3,
        KIND_BAD_CHAR  = 3'd4,
        KIND_END_OK    = 3'd5,
        KIND_END_ERR   = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_NUM     = 4'b0010,
        MODE_COMMENT = 4'b0100,
        MODE_ERROR   = 4'b1000
    } t_lex_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [3:0]  digit_count;
        logic [7:0]  bad_char;
        logic        last;
    } t_result;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
            default:       r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/hexlex_if.sv
interface hexlex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface hexlex_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [3:0]  digit_count;
    logic [7:0]  bad_char;
    logic        last;

    modport source (output valid, output kind, output value, output digit_count,
                    output bad_char, output last, input ready);
    modport sink   (input valid, input kind, input value, input digit_count,
                    input bad_char, input last, output ready);
endinterface

// File: hw/rtl/hexlex_core.sv
module hexlex_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_ch,
    input  logic                i_is_end,
    output logic [1:0]          o_res_cnt,
    output hexlex_pkg::t_result o_res0,
    output hexlex_pkg::t_result o_res1
);
    import hexlex_pkg::*;

    t_lex_mode   r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_dig, n_dig;

    logic [1:0]  w_cnt;
    t_result     w_res0, w_res1, w_bad;
    logic [4:0]  w_hex;
    logic [31:0] w_acc_sh;
    logic [3:0]  w_dig_inc;
    logic        w_scan, w_slot1;

    function automatic logic run_ok(input logic [3:0] d);
        return (d inside {4'd2, 4'd4, MAX_DIGITS});
    endfunction

    // token or digit-count error for a closed run
    function automatic t_result close_run(input logic [31:0] acc, input logic [3:0] d);
        t_result r;
        r = '0;
        r.digit_count = d;
        case (d)
            4'd2: begin
                r.kind  = KIND_BYTE;
                r.value = {24'd0, acc[7:0]};
            end
            4'd4: begin
                r.kind  = KIND_HALF;
                r.value = {16'd0, acc[15:0]};
            end
            MAX_DIGITS: begin
                r.kind  = KIND_WORD;
                r.value = acc;
            end
            default: r.kind = KIND_BAD_COUNT;
        endcase
        return r;
    endfunction

    function automatic t_result end_result(input logic bad);
        t_result r;
        r      = '0;
        r.kind = bad ? KIND_END_ERR : KIND_END_OK;
        r.last = 1'b1;
        return r;
    endfunction

    assign w_hex     = hex_nibble(i_ch);
    assign w_acc_sh  = {r_acc[27:0], w_hex[3:0]};
    assign w_dig_inc = r_dig + 4'd1;

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_dig   = r_dig;
        w_cnt   = 2'd0;
        w_res0  = '0;
        w_res1  = '0;
        w_scan  = 1'b0;
        w_slot1 = 1'b0;
        w_bad   = '0;
        w_bad.kind     = KIND_BAD_CHAR;
        w_bad.bad_char = i_ch;

        if (i_is_end) begin
            if (r_mode == MODE_NUM) begin
                w_res0 = close_run(r_acc, r_dig);
                w_res1 = end_result(!run_ok(r_dig));
                w_cnt  = 2'd2;
            end else begin
                w_res0 = end_result(r_mode == MODE_ERROR);
                w_cnt  = 2'd1;
            end
            n_mode = MODE_IDLE;
            n_acc  = '0;
            n_dig  = '0;
        end else begin
            case (r_mode)
                MODE_ERROR: ;
                MODE_COMMENT: begin
                    if (i_ch == CH_LF) n_mode = MODE_IDLE;
                end
                MODE_NUM: begin
                    if (w_hex[4]) begin
                        n_acc = w_acc_sh;
                        n_dig = w_dig_inc;
                        if (w_dig_inc == MAX_DIGITS) begin
                            w_res0 = close_run(w_acc_sh, w_dig_inc);
                            w_cnt  = 2'd1;
                            n_mode = MODE_IDLE;
                            n_acc  = '0;
                            n_dig  = '0;
                        end
                    end else begin
                        w_res0 = close_run(r_acc, r_dig);
                        w_cnt  = 2'd1;
                        n_acc  = '0;
                        n_dig  = '0;
                        if (run_ok(r_dig)) begin
                            // good run: closing char is then scanned as in idle
                            n_mode  = MODE_IDLE;
                            w_scan  = 1'b1;
                            w_slot1 = 1'b1;
                        end else begin
                            n_mode = MODE_ERROR;
                        end
                    end
                end
                MODE_IDLE: w_scan = 1'b1;
                default: ;
            endcase

            if (w_scan) begin
                if (w_hex[4]) begin
                    n_mode = MODE_NUM;
                    n_acc  = {28'd0, w_hex[3:0]};
                    n_dig  = 4'd1;
                end else if (i_ch == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (i_ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                    // whitespace, skipped
                end else begin
                    n_mode = MODE_ERROR;
                    if (w_slot1) begin
                        w_res1 = w_bad;
                        w_cnt  = 2'd2;
                    end else begin
                        w_res0 = w_bad;
                        w_cnt  = 2'd1;
                    end
                end
            end
        end
    end

    assign o_res_cnt = i_accept ? w_cnt : 2'd0;
    assign o_res0    = w_res0;
    assign o_res1    = w_res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_dig  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_dig  <= n_dig;
        end
    end

endmodule

// File: hw/rtl/hexlex_outq.sv
module hexlex_outq #(
    parameter int unsigned DEPTH = hexlex_pkg::OQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  hexlex_pkg::t_result i_res0,
    input  hexlex_pkg::t_result i_res1,
    output logic                o_room,
    hexlex_out_if.source        o_out
);
    import hexlex_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_q [DEPTH];
    t_result         n_q [DEPTH];
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   w_mid, w_mid1;
    logic            w_pop;

    always_comb begin
        w_pop  = (r_cnt != '0) && o_out.ready;
        w_mid  = r_cnt - CW'(w_pop);
        w_mid1 = w_mid + CW'(1);
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
            if (w_pop && i < DEPTH - 1) n_q[i] = r_q[(i + 1) % DEPTH];
            if (i_push_cnt != 2'd0 && CW'(i) == w_mid) n_q[i] = i_res0;
            if (i_push_cnt == 2'd2 && CW'(i) == w_mid1) n_q[i] = i_res1;
        end
        n_cnt = w_mid + CW'(i_push_cnt);
    end

    // room for the two results one item can give
    assign o_room = (r_cnt <= CW'(DEPTH - 2));

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.kind        = r_q[0].kind;
    assign o_out.value       = r_q[0].value;
    assign o_out.digit_count = r_q[0].digit_count;
    assign o_out.bad_char    = r_q[0].bad_char;
    assign o_out.last        = r_q[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

// File: hw/rtl/hex_token_lexer.sv
// Streaming lexer for hex text, one character word per handshake.
// Input channel i_in: ch (byte) and is_end (end of text). Output channel
// o_out: kind, value, digit_count, bad_char, last.
// Hex digit runs are packed MSB first; runs of 2, 4 or 8 digits give byte,
// half and word tokens, other lengths a digit-count error. A run closes at 8
// digits. Whitespace is skipped, '#' comments run to LF, other bytes are an
// invalid-character error; after an error words are dropped until is_end.
// The end word always gives a result with last set.
// Timing: one input word per cycle while the queue has room. The lexer state is
// updated at the accept edge and the word's results land in a small result
// queue at that edge. A word with two results (run closed plus end, or run
// closed plus bad character) drains them one per cycle while o_out.ready is
// high. i_in.ready depends only on queue fill: it stays high while at least
// two free slots remain, so with o_out.ready high and one result per word the
// block sustains one word per cycle. When the receiver stalls, the queue
// fills and i_in.ready drops; nothing is lost and the head result holds.
// Reset (synchronous, active low) returns the lexer to idle with an empty
// accumulator and empties the result queue.
module hex_token_lexer #(
    parameter int unsigned OUT_DEPTH = hexlex_pkg::OQ_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hexlex_in_if.sink    i_in,
    hexlex_out_if.source o_out
);
    import hexlex_pkg::*;

    logic       w_accept;
    logic       w_room;
    logic [1:0] w_res_cnt;
    t_result    w_res0, w_res1;

    // ready is a queue-space check, independent of o_out.ready
    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid && w_room;

    hexlex_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_ch      (i_in.ch),
        .i_is_end  (i_in.is_end),
        .o_res_cnt (w_res_cnt),
        .o_res0    (w_res0),
        .o_res1    (w_res1)
    );

    // result queue: absorbs the second result of a word and receiver stalls
    hexlex_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_res_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_room     (w_room),
        .o_out      (o_out)
    );

endmodule

// File: hw/rtl/hexlex_chk.sv
`include "hex_token_lexer_macros.svh"

module hexlex_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [31:0] i_value,
    input logic [3:0]  i_digit_count,
    input logic        i_last
);
    import hexlex_pkg::*;

    logic w_stall;
    logic w_end_kind;
    logic w_byte_ok;

    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_end_kind = (i_kind == KIND_END_OK) || (i_kind == KIND_END_ERR);
    assign w_byte_ok  = (i_digit_count == 4'd2) && (i_value[31:8] == 24'd0);

    // queue is empty right after reset
    `HEXLEX_ASSERT_ALWAYS(a_empty_after_rst, !i_rst_n |=> !i_out_valid)

    // stalled result holds
    `HEXLEX_ASSERT(a_out_hold, w_stall |=> i_out_valid && $stable(i_kind) && $stable(i_value))

    // last marks exactly the end results
    `HEXLEX_ASSERT(a_last_kind, i_out_valid |-> i_last == w_end_kind)

    // byte token: two digits, value fits a byte
    `HEXLEX_ASSERT(a_byte_tok, i_out_valid && i_kind == KIND_BYTE |-> w_byte_ok)

endmodule

bind hex_token_lexer hexlex_chk u_hexlex_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_value       (o_out.value),
    .i_digit_count (o_out.digit_count),
    .i_last        (o_out.last)
);
